[design/psg_pkg.sv]
package psg_pkg;

  // Largest number of elements the block can permute.
  localparam int unsigned MAX_ELEMENTS = 8;

  // Width and reset value of the size register.
  localparam int unsigned SIZE_W = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd7;

  // One permutation position takes a nibble, eight positions fit in a result.
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned PERM_SLOTS = 8;
  localparam int unsigned PERM_W = SLOT_W * PERM_SLOTS;

  // Result beat handed from the sequencer to the output register.
  typedef struct packed {
    logic [PERM_W-1:0] permutation;
    logic              is_final;
    logic              exhausted;
  } result_t;

endpackage

[design/psg_if.sv]
interface psg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface psg_out_if;
  logic                        valid;
  logic                        ready;
  logic [psg_pkg::PERM_W-1:0]  permutation;
  logic                        is_final;
  logic                        exhausted;

  modport source (output valid, output permutation, output is_final, output exhausted,
                  input ready);
  modport sink (input valid, input permutation, input is_final, input exhausted,
                output ready);
endinterface

[design/permutation_sequence_generator.sv]
// Permutation sequence generator, Johnson-Trotter order.
// Each beat on req_i asks for the next permutation of 1..n; restart set in
// the beat returns to the identity order with all directions left first.
// Each request gives one beat on rsp_o: the permutation (position i in bits
// 4i+3..4i, unused positions zero), is_final on the last permutation, and
// exhausted when the sequence had already ended and the last one repeats.
// cfg_we_i writes n (cfg_wdata_i) and restarts the sequence; write it only
// while the block is idle.
// A request that advances the order passes an accept cycle, a scan over the
// positions by the shared compare unit, the swap states S_SWAP_A and S_SWAP_B
// and a handoff to the output register. A request after the end goes from
// accept straight to the handoff. The scan grows with n, and a new request
// is taken in the cycle after the handoff.
// The output register holds a result while rsp_o is stalled; the next
// request is still accepted and worked, and waits for the handoff.
// After reset n is 7, the order is the identity and all directions are left.
module permutation_sequence_generator #(
  parameter int unsigned MaxElements = psg_pkg::MAX_ELEMENTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  psg_in_if.sink                      req_i,
  psg_out_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [psg_pkg::SIZE_W-1:0]  cfg_wdata_i
);

  logic [psg_pkg::SIZE_W-1:0] size_q;
  logic                       out_valid_q;
  psg_pkg::result_t           out_q;
  logic                       core_idle;
  logic                       core_valid;
  psg_pkg::result_t           core_res;
  logic                       take;
  logic                       start;

  assign start = req_i.valid && core_idle;
  assign take  = core_valid && (!out_valid_q || rsp_o.ready);

  psg_core #(
    .MaxElements (MaxElements)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .restart_i   (req_i.restart),
    .clear_i     (cfg_we_i),
    .size_i      (size_q),
    .idle_o      (core_idle),
    .res_valid_o (core_valid),
    .res_o       (core_res),
    .res_take_i  (take)
  );

  // Size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= psg_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= core_res;
    end
  end

  assign req_i.ready       = core_idle;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.permutation = out_q.permutation;
  assign rsp_o.is_final    = out_q.is_final;
  assign rsp_o.exhausted   = out_q.exhausted;

endmodule

[design/psg_core.sv]
module psg_core #(
  parameter int unsigned MaxElements = psg_pkg::MAX_ELEMENTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        restart_i,
  input  logic                        clear_i,
  input  logic [psg_pkg::SIZE_W-1:0]  size_i,
  output logic                        idle_o,
  output logic                        res_valid_o,
  output psg_pkg::result_t            res_o,
  input  logic                        res_take_i
);

  localparam int unsigned VW = $clog2(MaxElements + 1);
  localparam int unsigned IW = $clog2(MaxElements);
  localparam int unsigned PackN =
      (MaxElements < psg_pkg::PERM_SLOTS) ? MaxElements : psg_pkg::PERM_SLOTS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SWAP_A = 3'd2;
  localparam logic [2:0] S_SWAP_B = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [VW-1:0] order_q [MaxElements];
  logic [MaxElements-1:0] dir_q;
  logic          finished_q;

  logic [VW-1:0] idx_q;
  logic [VW-1:0] p1_q, p2_q;
  logic [VW-1:0] best_val_q;
  logic [IW-1:0] best_pos_q;
  logic [VW-1:0] best_nb_q;
  logic          best_dir_q;

  logic [psg_pkg::PERM_W-1:0] perm_q;
  logic          final_q, exh_q;

  logic [VW-1:0] n;
  logic [VW-1:0] src [MaxElements];
  logic [psg_pkg::PERM_W-1:0] packed_perm;
  logic [VW-1:0] cur;
  logic          p1_dir;
  logic          has_right, has_left;
  logic [VW-1:0] nb;
  logic          nb_ok;
  logic          mobile;
  logic          found;
  logic          done_scan;
  logic [IW-1:0] other;

  // Effective element count: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    if (size_i == '0) begin
      n = VW'(1);
    end else if (32'(size_i) > MaxElements) begin
      n = VW'(MaxElements);
    end else begin
      n = VW'(size_i);
    end
  end

  // Permutation as it is emitted, taking a restart into account.
  always_comb begin
    packed_perm = '0;
    for (int i = 0; i < MaxElements; i++) begin
      src[i] = restart_i ? VW'(i + 1) : order_q[i];
    end
    for (int i = 0; i < PackN; i++) begin
      if (VW'(i) < n) begin
        packed_perm[psg_pkg::SLOT_W*i +: psg_pkg::SLOT_W] = psg_pkg::SLOT_W'(src[i]);
      end
    end
  end

  // Shared compare unit: one position is judged per scan beat. The window
  // p2, p1, cur holds the positions idx-2, idx-1 and idx.
  always_comb begin
    cur       = (idx_q < n) ? order_q[idx_q[IW-1:0]] : '0;
    p1_dir    = dir_q[IW'(p1_q - VW'(1))];
    has_right = idx_q < n;
    has_left  = idx_q >= VW'(2);
    nb        = p1_dir ? cur : p2_q;
    nb_ok     = p1_dir ? has_right : has_left;
    mobile    = (idx_q != '0) && nb_ok && (p1_q > nb) && (p1_q > best_val_q);
    found     = mobile || (best_val_q != '0);
    done_scan = idx_q == n;
    other     = best_dir_q ? (best_pos_q + IW'(1)) : (best_pos_q - IW'(1));
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = (finished_q && !restart_i) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (done_scan) begin
          state_d = found ? S_SWAP_A : S_DONE;
        end
      end
      S_SWAP_A: state_d = S_SWAP_B;
      S_SWAP_B: state_d = S_DONE;
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and the permutation itself.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      finished_q <= 1'b0;
      dir_q      <= '0;
      for (int i = 0; i < MaxElements; i++) begin
        order_q[i] <= VW'(i + 1);
      end
    end else begin
      state_q <= state_d;
      if (clear_i || (state_q == S_IDLE && start_i && restart_i)) begin
        finished_q <= 1'b0;
        dir_q      <= '0;
        for (int i = 0; i < MaxElements; i++) begin
          order_q[i] <= VW'(i + 1);
        end
      end
      if (state_q == S_SCAN && done_scan && !found) begin
        finished_q <= 1'b1;
      end
      if (state_q == S_SWAP_A) begin
        order_q[best_pos_q] <= best_nb_q;
      end
      if (state_q == S_SWAP_B) begin
        order_q[other] <= best_val_q;
        // Every value above the moved one, up to n, changes direction.
        for (int k = 0; k < MaxElements; k++) begin
          if (VW'(k + 1) > best_val_q && VW'(k + 1) <= n) begin
            dir_q[k] <= ~dir_q[k];
          end
        end
      end
    end
  end

  // Scan window, best candidate and result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      idx_q      <= '0;
      p1_q       <= '0;
      p2_q       <= '0;
      best_val_q <= '0;
      perm_q     <= packed_perm;
      final_q    <= finished_q && !restart_i;
      exh_q      <= finished_q && !restart_i;
    end
    if (state_q == S_SCAN) begin
      p2_q  <= p1_q;
      p1_q  <= cur;
      idx_q <= idx_q + VW'(1);
      if (mobile) begin
        best_val_q <= p1_q;
        best_pos_q <= IW'(idx_q - VW'(1));
        best_nb_q  <= nb;
        best_dir_q <= p1_dir;
      end
      if (done_scan && !found) begin
        final_q <= 1'b1;
      end
    end
  end

  assign idle_o            = state_q == S_IDLE;
  assign res_valid_o       = state_q == S_DONE;
  assign res_o.permutation = perm_q;
  assign res_o.is_final    = final_q;
  assign res_o.exhausted   = exh_q;

endmodule

[test/permutation_sequence_generator_tb.sv]
`timescale 1ns / 100ps

// Tracks the Johnson-Trotter state of the block and holds the permutations it owes.
class jt_perm_scoreboard;
  logic [psg_pkg::SIZE_W-1:0] size_reg;
  logic [3:0]                 order [psg_pkg::MAX_ELEMENTS];
  bit                         heads_right [psg_pkg::MAX_ELEMENTS];
  bit                         ended;
  psg_pkg::result_t           pending_perms [$];
  int unsigned                errors;

  function new();
    size_reg = psg_pkg::SIZE_RESET;
    errors = 0;
    rewind();
  endfunction

  // Identity order, every value heading left, sequence not yet ended.
  function void rewind();
    int i;
    for (i = 0; i < psg_pkg::MAX_ELEMENTS; i++) begin
      order[i] = 4'(i + 1);
      heads_right[i] = 1'b0;
    end
    ended = 1'b0;
  endfunction

  // A size write also restarts the sequence.
  function void write_size(logic [psg_pkg::SIZE_W-1:0] value);
    size_reg = value;
    rewind();
  endfunction

  // Zero counts as one element, anything above the maximum as the maximum.
  function int unsigned active_count();
    int unsigned n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > psg_pkg::MAX_ELEMENTS) n = psg_pkg::MAX_ELEMENTS;
    return n;
  endfunction

  function int unsigned pending();
    return pending_perms.size();
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // Work out the beat owed for one accepted request and advance the order if it can.
  function void note_request(bit restart);
    psg_pkg::result_t r;
    int unsigned      n, i, pos, top, peer;
    bit               found;
    logic [3:0]       v, nb;
    n = active_count();
    if (restart) rewind();
    r = '0;
    for (i = 0; i < n && i < psg_pkg::PERM_SLOTS; i++) begin
      r.permutation[psg_pkg::SLOT_W*i +: psg_pkg::SLOT_W] = order[i];
    end
    // After the end the last permutation repeats and the state stays put.
    if (ended) begin
      r.is_final = 1'b1;
      r.exhausted = 1'b1;
      pending_perms.push_back(r);
      return;
    end
    // Find the largest value that points at a smaller neighbor.
    found = 1'b0;
    top = 0;
    pos = 0;
    for (i = 0; i < n; i++) begin
      v = order[i];
      if (heads_right[v-1]) begin
        if (i + 1 >= n) continue;
        nb = order[i+1];
      end else begin
        if (i == 0) continue;
        nb = order[i-1];
      end
      if (v > nb && v > top) begin
        top = v;
        pos = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      ended = 1'b1;
      r.is_final = 1'b1;
    end else begin
      // Move the mobile value one step and turn every larger value around.
      peer = heads_right[top-1] ? pos + 1 : pos - 1;
      v = order[pos];
      order[pos] = order[peer];
      order[peer] = v;
      for (i = 0; i < n; i++) begin
        if (order[i] > top) heads_right[order[i]-1] = ~heads_right[order[i]-1];
      end
    end
    pending_perms.push_back(r);
  endfunction

  // Compare one output beat with the oldest permutation owed.
  function void check_result(psg_pkg::result_t got);
    psg_pkg::result_t want;
    if (pending_perms.size() == 0) begin
      report($sformatf("unexpected beat: perm %h final %b exhausted %b",
                       got.permutation, got.is_final, got.exhausted));
      return;
    end
    want = pending_perms.pop_front();
    if (got.permutation !== want.permutation || got.is_final !== want.is_final ||
        got.exhausted !== want.exhausted) begin
      report($sformatf("mismatch: expected %h final %b exh %b, got %h final %b exh %b",
                       want.permutation, want.is_final, want.exhausted,
                       got.permutation, got.is_final, got.exhausted));
    end
  endfunction
endclass

module permutation_sequence_generator_tb;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [psg_pkg::SIZE_W-1:0] cfg_wdata_i;

  psg_in_if  req_if ();
  psg_out_if rsp_if ();

  jt_perm_scoreboard sb = new();

  bit          src_idles;
  bit          sink_idles;
  int unsigned hold_off_len;
  int unsigned random_items;

  always #10 clk_i = ~clk_i;

  permutation_sequence_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Offer one request beat after an optional gap and wait until it is taken.
  task automatic send_request(input bit restart);
    int unsigned gap;
    gap = src_idles ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.restart <= restart;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(restart);
  endtask

  // Stop offering and wait until every owed beat has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Write the size register; the block is idle whenever this is called.
  task automatic write_size(input logic [psg_pkg::SIZE_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_size(value);
    cfg_we_i <= 1'b0;
  endtask

  // Output side: before each beat, ready may drop for a random gap or a set hold-off.
  initial begin : rsp_sink
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_len > 0) begin
        gap = hold_off_len;
        hold_off_len = 0;
      end else begin
        gap = sink_idles ? $urandom_range(0, 16) : 0;
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      sb.check_result('{permutation: rsp_if.permutation, is_final: rsp_if.is_final,
                        exhausted: rsp_if.exhausted});
    end
  end

  // Stimulus: directed corners first, then random phases over many sizes.
  initial begin : stimulus
    logic [psg_pkg::SIZE_W-1:0] size;
    int unsigned                phase, count, k, mode;
    bit                         noisy, restart;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    req_if.valid <= 1'b0;
    req_if.restart <= 1'b0;
    src_idles = 1'b0;
    sink_idles = 1'b0;
    hold_off_len = 0;
    random_items = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size of seven: a few steps, a restart, then more steps.
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    drain_results();

    // A single element is final at once, then repeats as exhausted.
    src_idles = 1'b1;
    sink_idles = 1'b1;
    write_size(4'd1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain_results();

    // Two elements: full sequence, one repeat, then a restart.
    write_size(4'd2);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain_results();

    // Size zero behaves as one element.
    write_size(4'd0);
    send_request(1'b0);
    send_request(1'b0);
    drain_results();

    // An oversized value behaves as the maximum.
    write_size(4'd15);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain_results();

    write_size(4'd8);
    send_request(1'b0);
    send_request(1'b0);
    drain_results();

    // Random phases: mostly small sizes so whole sequences run to their end.
    phase = 0;
    while (random_items < 1250) begin
      if ($urandom_range(0, 9) < 7) size = psg_pkg::SIZE_W'($urandom_range(1, 5));
      else size = psg_pkg::SIZE_W'($urandom_range(0, 15));
      write_size(size);
      mode = (phase == 0) ? 3 : $urandom_range(0, 3);
      src_idles = (mode == 1) || (mode == 2);
      sink_idles = (mode == 1) || (mode == 3);
      noisy = ($urandom_range(0, 4) == 0);
      count = (phase < 2) ? 120 : $urandom_range(20, 150);
      for (k = 0; k < count; k++) begin
        // Long receiver stall while requests keep coming.
        if (phase == 0 && k == 10) hold_off_len = 300;
        // Sender pause until all owed beats are back.
        if (phase == 1 && k == 40) drain_results();
        restart = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
        send_request(restart);
        random_items++;
      end
      drain_results();
      phase++;
    end

    // Allow for any stray beat after the last one owed.
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d beats never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
